/* sv/csc_pkg.sv */
package csc_pkg;

  // Default width of the running value and of the arithmetic.
  localparam int CSC_VALUE_WIDTH = 32;

  localparam int CHAR_W   = 8;
  localparam int RESULT_W = 32;
  localparam int STATUS_W = 2;

  // Recognized characters.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  // Status codes.
  localparam logic [STATUS_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ERR_DIV_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ERR_SATURATED = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } csc_op_e;

  typedef enum logic [2:0] {
    PH_SEEK_DIGIT = 3'b001,
    PH_GATHER     = 3'b010,
    PH_SEEK_OP    = 3'b100
  } csc_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_EMIT = 3'b100
  } csc_state_e;

  // Request from the control path to the serial multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } csc_md_ctrl_t;

endpackage

/* sv/csc_in_if.sv */
interface csc_in_if import csc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* sv/csc_out_if.sv */
interface csc_out_if import csc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

/* sv/csc_muldiv.sv */
// Bit-serial multiply (shift and add) and restoring divide, one bit per cycle.
module csc_muldiv import csc_pkg::*; #(
  parameter int VALUE_WIDTH = CSC_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csc_md_ctrl_t           ctrl_i,
  input  logic [VALUE_WIDTH-1:0] lhs_i,
  input  logic [VALUE_WIDTH-2:0] rhs_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] res_o
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q;
  logic                   done_q;
  logic                   is_div_q;
  logic                   neg_q;
  logic [CntW-1:0]        cnt_q;
  logic [VALUE_WIDTH-1:0] a_q;
  logic [VALUE_WIDTH-2:0] b_q;
  logic [VALUE_WIDTH-1:0] acc_q;

  logic [VALUE_WIDTH-1:0] mul_sum;
  logic [VALUE_WIDTH-1:0] trial;
  logic [VALUE_WIDTH-1:0] divisor;
  logic [VALUE_WIDTH-1:0] diff;
  logic                   fits;

  // Multiply: a_q is the shifted multiplicand, b_q the multiplier, acc_q the product.
  // Divide: a_q shifts the dividend out and the quotient in, acc_q holds the remainder.
  assign mul_sum = acc_q + (b_q[0] ? a_q : '0);
  assign trial   = {acc_q[VALUE_WIDTH-2:0], a_q[VALUE_WIDTH-1]};
  assign divisor = {1'b0, b_q};
  assign diff    = trial - divisor;
  assign fits    = (trial >= divisor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      is_div_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q   <= 1'b1;
        is_div_q <= ctrl_i.is_div;
        cnt_q    <= ctrl_i.is_div ? CntW'(VALUE_WIDTH) : CntW'(VALUE_WIDTH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
      b_q   <= rhs_i;
      neg_q <= ctrl_i.is_div & lhs_i[VALUE_WIDTH-1];
      if (ctrl_i.is_div && lhs_i[VALUE_WIDTH-1]) begin
        a_q <= '0 - lhs_i;
      end else begin
        a_q <= lhs_i;
      end
    end else if (busy_q) begin
      if (is_div_q) begin
        acc_q <= fits ? diff : trial;
        a_q   <= {a_q[VALUE_WIDTH-2:0], fits};
      end else begin
        acc_q <= mul_sum;
        a_q   <= {a_q[VALUE_WIDTH-2:0], 1'b0};
        b_q   <= {1'b0, b_q[VALUE_WIDTH-2:1]};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = is_div_q ? (neg_q ? ('0 - a_q) : a_q) : acc_q;

endmodule

/* sv/char_stream_calculator_core.sv */
// An item that commits no product or quotient is absorbed as it is accepted; a multiply
// or a divide by a nonzero number waits in ST_BUSY until the bit-serial unit is done.
// Throughput: one beat per cycle, except while the bit-serial multiply/divide unit runs
// or a result waits in ST_EMIT, since ready is low outside ST_IDLE.
// A final beat leads to ST_EMIT, which loads the result into the output register once it is free.
// Reset (rst_ni, asynchronous, active low) clears the calculator state and the output valid.
module char_stream_calculator_core import csc_pkg::*; #(
  parameter int VALUE_WIDTH = CSC_VALUE_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csc_in_if.sink     in_i,
  csc_out_if.source  out_o
);

  localparam int AccW  = VALUE_WIDTH - 1;
  localparam int ProdW = VALUE_WIDTH + 3;

  // Control state.
  csc_state_e             st_q, st_d;
  csc_phase_e             phase_q, phase_d;
  csc_op_e                op_q, op_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic                   have_q, have_d;
  logic [VALUE_WIDTH-1:0] rv_q, rv_d;
  logic [STATUS_W-1:0]    err_q, err_d;
  logic                   last_q, last_d;
  logic                   out_valid_q, out_valid_d;

  // Output payload register.
  logic [RESULT_W-1:0]    out_result_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [RESULT_W-1:0]    rv_low;

  // Character decode.
  logic                   accept;
  logic                   is_digit;
  logic                   is_op;
  csc_op_e                op_code;
  logic [ProdW-1:0]       acc_ext;
  logic [ProdW-1:0]       scaled;
  logic                   sat;
  logic [AccW-1:0]        acc_next;

  // Per-beat decisions.
  logic                   gather_digit;
  logic                   end_number;
  logic                   abort_gather;
  logic                   take_op;
  logic                   commit;
  logic [AccW-1:0]        commit_num;
  logic                   flag_sat;
  logic                   flag_dz;
  logic                   emit_fire;

  // Serial arithmetic unit.
  csc_md_ctrl_t           md_ctrl;
  logic                   md_done;
  logic [VALUE_WIDTH-1:0] md_res;

  csc_muldiv #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl),
    .lhs_i  (rv_q),
    .rhs_i  (commit_num),
    .done_o (md_done),
    .res_o  (md_res)
  );

  assign in_i.ready = (st_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // A digit's value is the low nibble of its ASCII code.
  assign is_digit = (in_i.character >= CH_ZERO) && (in_i.character <= CH_NINE);

  always_comb begin
    is_op   = 1'b1;
    op_code = OP_ADD;
    unique case (in_i.character)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      CH_SLASH: op_code = OP_DIV;
      default:  is_op   = 1'b0;
    endcase
  end

  // Accumulator times ten plus the digit; any bit at or above the sign position of
  // the value means the number left the positive range and saturates.
  assign acc_ext  = ProdW'(acc_q);
  assign scaled   = (acc_ext << 3) + (acc_ext << 1) + ProdW'(in_i.character[3:0]);
  assign sat      = |scaled[ProdW-1:AccW];
  assign acc_next = sat ? '1 : scaled[AccW-1:0];

  // A non-digit while gathering ends the number, and that same character may then be
  // taken as the operator. On a final beat a trailing space is implied, which commits a
  // number that the final character extended.
  assign gather_digit = is_digit && ((phase_q == PH_SEEK_DIGIT) || (phase_q == PH_GATHER));
  assign end_number   = !is_digit && (phase_q == PH_GATHER) && have_q;
  assign abort_gather = !is_digit && (phase_q == PH_GATHER) && !have_q;
  assign take_op      = is_op && (end_number || (phase_q == PH_SEEK_OP));
  assign commit       = end_number || (gather_digit && in_i.last);
  assign commit_num   = gather_digit ? acc_next : acc_q;

  assign emit_fire = (st_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    op_d        = op_q;
    acc_d       = acc_q;
    have_d      = have_q;
    rv_d        = rv_q;
    err_d       = err_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    md_ctrl     = '0;
    flag_sat    = 1'b0;
    flag_dz     = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = in_i.last;
          if (gather_digit) begin
            acc_d    = acc_next;
            have_d   = 1'b1;
            phase_d  = PH_GATHER;
            flag_sat = sat;
          end
          if (abort_gather) begin
            phase_d = PH_SEEK_DIGIT;
          end
          if (commit) begin
            acc_d   = '0;
            have_d  = 1'b0;
            phase_d = PH_SEEK_OP;
            unique case (op_q)
              OP_NONE: rv_d = {1'b0, commit_num};
              OP_ADD:  rv_d = rv_q + {1'b0, commit_num};
              OP_SUB:  rv_d = rv_q - {1'b0, commit_num};
              OP_MUL: begin
                md_ctrl.start  = 1'b1;
                md_ctrl.is_div = 1'b0;
              end
              OP_DIV: begin
                if (commit_num == '0) begin
                  flag_dz = 1'b1;
                end else begin
                  md_ctrl.start  = 1'b1;
                  md_ctrl.is_div = 1'b1;
                end
              end
              default: rv_d = rv_q;
            endcase
          end
          if (take_op) begin
            op_d    = op_code;
            phase_d = PH_SEEK_DIGIT;
          end
          // The first error sticks until the expression ends.
          if (err_q == ERR_NONE) begin
            if (flag_sat) begin
              err_d = ERR_SATURATED;
            end else if (flag_dz) begin
              err_d = ERR_DIV_ZERO;
            end
          end
          if (md_ctrl.start) begin
            st_d = ST_BUSY;
          end else if (in_i.last) begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_BUSY: begin
        if (md_done) begin
          rv_d = md_res;
          st_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          phase_d     = PH_SEEK_DIGIT;
          op_d        = OP_NONE;
          acc_d       = '0;
          have_d      = 1'b0;
          rv_d        = '0;
          err_d       = ERR_NONE;
          last_d      = 1'b0;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_SEEK_DIGIT;
      op_q        <= OP_NONE;
      acc_q       <= '0;
      have_q      <= 1'b0;
      rv_q        <= '0;
      err_q       <= ERR_NONE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      op_q        <= op_d;
      acc_q       <= acc_d;
      have_q      <= have_d;
      rv_q        <= rv_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result carries the low 32 bits of the running value, zero-extended when
  // the value is narrower.
  if (VALUE_WIDTH >= RESULT_W) begin : g_res_trunc
    assign rv_low = rv_q[RESULT_W-1:0];
  end else begin : g_res_ext
    assign rv_low = {{(RESULT_W - VALUE_WIDTH){1'b0}}, rv_q};
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_result_q <= rv_low;
      out_status_q <= err_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_result_q;
  assign out_o.status = out_status_q;

`ifndef SYNTHESIS
  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (st_q == ST_BUSY))
    else $error("serial unit finished outside the busy state");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (out_valid_q && rv_q == '0 && err_q == ERR_NONE &&
                   phase_q == PH_SEEK_DIGIT && op_q == OP_NONE))
    else $error("state not cleared after a result was loaded");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == ERR_NONE) || (err_q == ERR_DIV_ZERO) || (err_q == ERR_SATURATED))
    else $error("undefined error code");

  a_have_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (phase_q == PH_GATHER))
    else $error("digit pending outside the gather phase");

  a_acc_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q != '0) |-> have_q)
    else $error("accumulator holds a number with no digit gathered");
`endif

endmodule

/* bench/char_stream_calculator_core_test.sv */
module char_stream_calculator_core_test;
  import csc_pkg::*;

  // The run ends with a failure if it is still going after this many clocks.
  // A correct run ends well before that limit, even if every beat waits
  // on a divide.
  localparam int CYCLE_LIMIT = 800_000;

  // Random characters queued per random phase at the least, four phases in all.
  localparam int PHASE_BEATS = 425;

  // Clocks to wait after the last result. This covers a divide that might
  // still be running and the load of the output register.
  localparam int TAIL_CYCLES = 3 * (CSC_VALUE_WIDTH + 2);

  localparam logic [CHAR_W-1:0]   CH_SPACE = 8'h20;
  localparam logic [RESULT_W-1:0] NUM_MAX  = {1'b0, {(RESULT_W-1){1'b1}}};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic        [STATUS_W-1:0] status;
  } calc_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csc_in_if  in_if ();
  csc_out_if out_if ();

  char_stream_calculator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The bench drives its own registers and ties them to the interfaces, so
  // every input of the block is known from time zero.
  logic              drv_valid  = 1'b0;
  logic [CHAR_W-1:0] drv_char   = '0;
  logic              drv_last   = 1'b0;
  logic              sink_ready = 1'b0;

  assign in_if.valid     = drv_valid;
  assign in_if.character = drv_char;
  assign in_if.last      = drv_last;
  assign out_if.ready    = sink_ready;

  // Characters still to be sent, and the expected results of accepted
  // characters that have not yet been checked.
  char_beat_t   pending_chars[$];
  calc_result_t expected_results[$];
  char_beat_t   next_char;

  // Idle percentages. The stimulus process changes them between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int error_count = 0;
  int cycle_count = 0;

  // This is the calculator's own state, tracked here. The number being
  // gathered never goes above NUM_MAX, so it fits in a result-wide vector.
  csc_phase_e          calc_phase      = PH_SEEK_DIGIT;
  csc_op_e             calc_op         = OP_NONE;
  logic [RESULT_W-1:0] calc_num        = '0;
  logic                calc_have_digit = 1'b0;
  logic [RESULT_W-1:0] calc_value      = '0;
  logic [STATUS_W-1:0] calc_err        = ERR_NONE;

  function automatic void clear_calc();
    calc_phase      = PH_SEEK_DIGIT;
    calc_op         = OP_NONE;
    calc_num        = '0;
    calc_have_digit = 1'b0;
    calc_value      = '0;
    calc_err        = ERR_NONE;
  endfunction

  // Only the first error of an expression is kept.
  function automatic void note_error(logic [STATUS_W-1:0] code);
    if (calc_err == ERR_NONE) calc_err = code;
  endfunction

  // This commits the gathered number. With no operator pending, the number
  // seeds the value. Otherwise the pending operator combines the number
  // with the value, and the sum, difference and product wrap at 32 bits.
  // Division works on magnitudes and truncates toward zero. The most
  // negative value has a magnitude of 2^31, which is still correct as an
  // unsigned number.
  function automatic void fold_number();
    logic [RESULT_W-1:0] mag;
    logic [RESULT_W-1:0] quo;
    case (calc_op)
      OP_NONE: calc_value = calc_num;
      OP_ADD:  calc_value = calc_value + calc_num;
      OP_SUB:  calc_value = calc_value - calc_num;
      OP_MUL:  calc_value = calc_value * calc_num;
      default: begin
        if (calc_num == '0) begin
          note_error(ERR_DIV_ZERO);
        end else begin
          mag        = calc_value[RESULT_W-1] ? -calc_value : calc_value;
          quo        = mag / calc_num;
          calc_value = calc_value[RESULT_W-1] ? -quo : quo;
        end
      end
    endcase
    calc_num        = '0;
    calc_have_digit = 1'b0;
    calc_phase      = PH_SEEK_OP;
  endfunction

  // One character through the three phases. A character that ends a
  // number falls through, so it can also be taken as the next operator.
  // Digits that arrive while an operator is sought are skipped.
  function automatic void feed_char(logic [CHAR_W-1:0] c);
    logic                is_digit;
    logic [RESULT_W-1:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = RESULT_W'(c) - RESULT_W'(CH_ZERO);
    if (calc_phase == PH_SEEK_DIGIT) begin
      if (!is_digit) return;
      calc_phase = PH_GATHER;
    end
    if (calc_phase == PH_GATHER) begin
      if (is_digit) begin
        // A number that would pass 2^31-1 saturates there and sets the error.
        if (calc_num > (NUM_MAX - d) / 10) begin
          calc_num = NUM_MAX;
          note_error(ERR_SATURATED);
        end else begin
          calc_num = calc_num * 10 + d;
        end
        calc_have_digit = 1'b1;
        return;
      end
      if (!calc_have_digit) begin
        calc_phase = PH_SEEK_DIGIT;
        return;
      end
      fold_number();
    end
    case (c)
      CH_PLUS:  begin calc_op = OP_ADD; calc_phase = PH_SEEK_DIGIT; end
      CH_MINUS: begin calc_op = OP_SUB; calc_phase = PH_SEEK_DIGIT; end
      CH_STAR:  begin calc_op = OP_MUL; calc_phase = PH_SEEK_DIGIT; end
      CH_SLASH: begin calc_op = OP_DIV; calc_phase = PH_SEEK_DIGIT; end
      default: ;
    endcase
  endfunction

  // The final character of an expression is handled like any other. After
  // it, a space is fed in, so a number still being gathered gets committed.
  // The value and the status then become the expected result, and the
  // state is cleared for the next expression.
  function automatic void calc_accept(logic [CHAR_W-1:0] c, logic is_last);
    calc_result_t res;
    feed_char(c);
    if (is_last) begin
      feed_char(CH_SPACE);
      res.value  = calc_value;
      res.status = calc_err;
      expected_results.push_back(res);
      clear_calc();
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_result(logic signed [RESULT_W-1:0] got_value,
                              logic [STATUS_W-1:0] got_status);
    calc_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d status %0d", got_value, got_status));
      return;
    end
    want = expected_results.pop_front();
    if (got_value !== want.value)
      report_mismatch($sformatf("result %0d, expected %0d", got_value, want.value));
    if (got_status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
  endtask

  // Driver: a beat that is on the bus stays there until the block takes it.
  // The calculator state is advanced at the edge where the beat is
  // accepted. After that, the next character is offered unless the sender
  // decides to idle in this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) calc_accept(drv_char, drv_last);
      if (!drv_valid || in_if.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char = pending_chars.pop_front();
          drv_valid <= 1'b1;
          drv_char  <= next_char.ch;
          drv_last  <= next_char.last;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result beat is checked against the oldest expectation. The
  // ready for the next cycle is then drawn at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result(out_if.result, out_if.status);
      sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void queue_char(logic [CHAR_W-1:0] c, logic is_last);
    char_beat_t b;
    b.ch   = c;
    b.last = is_last;
    pending_chars.push_back(b);
  endfunction

  function automatic void queue_text(string s, logic end_here);
    for (int i = 0; i < s.len(); i++)
      queue_char(s[i], end_here && (i == s.len() - 1));
  endfunction

  function automatic void queue_operator();
    case ($urandom_range(3))
      0: queue_char(CH_PLUS, 1'b0);
      1: queue_char(CH_MINUS, 1'b0);
      2: queue_char(CH_STAR, 1'b0);
      default: queue_char(CH_SLASH, 1'b0);
    endcase
  endfunction

  // Most numbers are short, so the products and quotients stay readable.
  // About one in twelve has ten or eleven digits. Those wrap the value
  // when multiplied. Ten digits saturate at times, eleven nearly always.
  function automatic void queue_number();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 45)      len = 1;
    else if (pick < 75) len = $urandom_range(2, 3);
    else if (pick < 92) len = $urandom_range(4, 9);
    else                len = $urandom_range(10, 11);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && len == 10) queue_char(CHAR_W'(CH_ZERO + $urandom_range(1, 2)), 1'b0);
      else                     queue_char(CHAR_W'(CH_ZERO + $urandom_range(9)), 1'b0);
    end
  endfunction

  // This queues one expression and returns the number of beats it takes.
  // Nine expressions in ten are well formed, with spaces and stray bytes
  // mixed in. The tenth is a run of random bytes. Each expression ends
  // with a marked last beat. That beat is its final digit, a trailing
  // space, or a random byte.
  function automatic int queue_expression();
    int start;
    int n_terms;
    start = pending_chars.size();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) queue_char(CHAR_W'($urandom_range(255)), 1'b0);
    end else begin
      n_terms = $urandom_range(1, 5);
      for (int t = 0; t < n_terms; t++) begin
        if (t != 0) begin
          if ($urandom_range(3) == 0) queue_char(CH_SPACE, 1'b0);
          queue_operator();
          if ($urandom_range(5) == 0) queue_char(CHAR_W'($urandom_range(255)), 1'b0);
        end
        queue_number();
      end
    end
    case ($urandom_range(7))
      0: queue_char(CH_SPACE, 1'b1);
      1: queue_char(CHAR_W'($urandom_range(255)), 1'b1);
      default: pending_chars[pending_chars.size() - 1].last = 1'b1;
    endcase
    return pending_chars.size() - start;
  endfunction

  // This waits until everything queued has been sent and every expected
  // result has come back. Polling at the falling edge keeps the wait clear
  // of the updates made at the rising edge.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || drv_valid || expected_results.size() != 0);
  endtask

  initial begin
    int queued;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A ten-digit number saturates and raises the error. The value then
    // wraps to the most negative number. A later division by zero does
    // not replace the first error, and halving the negative value
    // truncates toward zero. The last beat is a digit.
    queue_text("2147483648+1/0/2", 1'b1);
    // In this expression, 0xFF is skipped while a digit is sought. The
    // space commits the 3, and the 5 after it is skipped because an
    // operator is sought there. The NUL on the last beat is skipped too.
    queue_text("8-9*", 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_text("3 5+", 1'b0);
    queue_char(8'h00, 1'b1);
    // A lone last beat with no digit in it gives zero.
    queue_char(8'h80, 1'b1);
    wait_drained();

    // These are the random phases: no idling, then a slow sender, then a
    // slow receiver, then both at once. The queue drains completely
    // between phases, so the sender sits idle until all the results are in.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      queued = 0;
      while (queued < PHASE_BEATS) queued += queue_expression();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
